// File: hdl/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants for the 3x3 image convolution block
// Pixel and column types, window cell control, result tags and the
// configuration register map.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int DEF_MAX_WIDTH      = 2048;
  localparam int DEF_COEF_FRAC_BITS = 8;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int COEF_W   = 16;
  // signed 16b coefficient times unsigned 8b channel fits in 24 bits
  localparam int PROD_W   = 24;
  localparam int CSUM_W   = PROD_W + 2;
  localparam int TOT_W    = CSUM_W + 2;

  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [WIDTH_W-1:0]    WIDTH_RST      = 12'd256;
  localparam logic [HEIGHT_W-1:0]   HEIGHT_RST     = 13'd256;
  localparam logic [CFG_DATA_W-1:0] KERNEL_LOW_RST = 64'd0;
  localparam logic [CFG_DATA_W-1:0] KERNEL_MID_RST = 64'd256;
  localparam logic [COEF_W-1:0]     KERNEL_TOP_RST = 16'd0;

  typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
  // index 0 is the top row of the column
  typedef pixel_t [2:0]                  column_t;
  typedef logic [2:0][COEF_W-1:0]        coef_col_t;
  typedef logic [NUM_CH-1:0][CSUM_W-1:0] col_sum_t;

  typedef enum logic [1:0] {
    WIN_HOLD,
    WIN_LOAD,
    WIN_SHIFT
  } win_op_t;

  typedef struct packed {
    logic    adv;
    win_op_t op;
  } win_ctl_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } emit_tag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH      = 3'd0,
    REG_HEIGHT     = 3'd1,
    REG_KERNEL_LOW = 3'd2,
    REG_KERNEL_MID = 3'd3,
    REG_KERNEL_TOP = 3'd4
  } cfg_reg_t;

endpackage

// File: hdl/convolution_3x3_image_top.sv
// Stages: update stage, window cells, product and column-sum registers, output.
// Throughput: one pixel beat per cycle unless the output stalls; the last pixel
//   of a row that yields two results stalls the source while the chain shifts again.
// Reset: synchronous; clears counters, pipeline valids, window and config to
//   defaults. Line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// convolution_3x3_image_top: streaming 3x3 RGBA convolution filter
// Two line stores feed a chain of three column cells holding the window;
// column sums are reduced, rounded and saturated per channel.
// ----------------------------------------------------------------------------
module convolution_3x3_image_top #(
  parameter int MAX_WIDTH      = conv3_pkg::DEF_MAX_WIDTH,
  parameter int COEF_FRAC_BITS = conv3_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel stream
  input  logic                                src_valid,
  output logic                                src_stall,
  input  logic [conv3_pkg::CH_W-1:0]          red_in,
  input  logic [conv3_pkg::CH_W-1:0]          green_in,
  input  logic [conv3_pkg::CH_W-1:0]          blue_in,
  input  logic [conv3_pkg::CH_W-1:0]          alpha_in,
  input  logic                                pad_item,
  // result stream
  output logic                                dst_valid,
  input  logic                                dst_stall,
  output logic [conv3_pkg::CH_W-1:0]          red_out,
  output logic [conv3_pkg::CH_W-1:0]          green_out,
  output logic [conv3_pkg::CH_W-1:0]          blue_out,
  output logic [conv3_pkg::CH_W-1:0]          alpha_out,
  output logic                                row_end,
  output logic                                frame_end
);
  import conv3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;

  // configuration registers
  logic [WIDTH_W-1:0]    image_width;
  logic [HEIGHT_W-1:0]   image_height;
  logic [CFG_DATA_W-1:0] kernel_low;
  logic [CFG_DATA_W-1:0] kernel_mid;
  logic [COEF_W-1:0]     kernel_top;

  // input position
  logic [AW-1:0]         column_count;
  logic [HEIGHT_W-1:0]   row_count;
  logic [WW-1:0]         width_ext;
  logic [WW-1:0]         w_eff;
  logic [HEIGHT_W-1:0]   h_eff;
  logic                  in_last;
  logic                  in_flush;
  logic                  accept;

  // window update stage
  logic                  b_valid;
  logic                  b_phase;
  pixel_t                b_pix;
  logic                  b_flush;
  logic                  b_last;
  logic                  b_col0;
  logic                  b_early;
  logic                  b_rows;
  logic [AW-1:0]         b_addr;
  logic                  b_fwd;
  logic                  b_two;
  logic                  fire;
  logic                  b_done;
  logic                  we;
  pixel_t                fwd_mid;
  pixel_t                fwd_bot;
  logic [PIX_W-1:0]      upper_q;
  logic [PIX_W-1:0]      lower_q;
  pixel_t                top_pix;
  pixel_t                mid_pix;
  pixel_t                bot_pix;

  // window chain and reduction
  logic                  adv;
  logic [8:0][COEF_W-1:0] coef;
  column_t               new_col;
  column_t               win_col [3];
  column_t               feed [3];
  win_ctl_t              cell_ctl [3];
  col_sum_t [2:0]        col_sums;
  emit_tag_t             emit_now;
  emit_tag_t             e1;
  emit_tag_t             e2;
  emit_tag_t             e3;
  pixel_t                out_pix;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      kernel_low   <= KERNEL_LOW_RST;
      kernel_mid   <= KERNEL_MID_RST;
      kernel_top   <= KERNEL_TOP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:      image_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:     image_height <= cfg_data[HEIGHT_W-1:0];
        REG_KERNEL_LOW: kernel_low   <= cfg_data;
        REG_KERNEL_MID: kernel_mid   <= cfg_data;
        REG_KERNEL_TOP: kernel_top   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef[3:0] = kernel_low;
  assign coef[7:4] = kernel_mid;
  assign coef[8]   = kernel_top;

  // ---------------------------------------------------------------- position
  assign width_ext = WW'(image_width);

  always_comb begin
    if (width_ext == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
  end

  assign h_eff    = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  assign in_last  = (WW'(column_count) + WW'(1)) >= w_eff;
  assign in_flush = row_count >= h_eff;
  assign accept   = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (in_last) begin
        column_count <= '0;
        row_count    <= in_flush ? '0 : row_count + HEIGHT_W'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- line stores
  conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (we),
    .waddr (b_addr),
    .wdata (mid_pix),
    .re    (accept),
    .raddr (column_count),
    .rdata (upper_q)
  );

  conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (we),
    .waddr (b_addr),
    .wdata (bot_pix),
    .re    (accept),
    .raddr (column_count),
    .rdata (lower_q)
  );

  // ---------------------------------------------------------------- update stage
  // a read issued in the same cycle as a write to that column takes the
  // written data from the bypass registers
  assign mid_pix = b_fwd ? fwd_bot : pixel_t'(lower_q);
  assign top_pix = b_early ? mid_pix : (b_fwd ? fwd_mid : pixel_t'(upper_q));
  assign bot_pix = b_flush ? mid_pix : b_pix;

  assign b_two     = b_last && b_rows && !b_col0;
  assign fire      = b_valid && adv;
  assign b_done    = fire && (!b_two || b_phase);
  assign we        = fire && !b_phase;
  assign src_stall = b_valid && !b_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        b_phase <= 1'b0;
      end else if (fire) begin
        b_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix   <= pad_item ? '0 : {alpha_in, blue_in, green_in, red_in};
      b_flush <= in_flush;
      b_last  <= in_last;
      b_col0  <= column_count == '0;
      b_early <= row_count <= HEIGHT_W'(1);
      b_rows  <= row_count != '0;
      b_addr  <= column_count;
      b_fwd   <= we && (b_addr == column_count);
    end
    if (we) begin
      fwd_mid <= mid_pix;
      fwd_bot <= bot_pix;
    end
  end

  // ---------------------------------------------------------------- window chain
  assign new_col[0] = top_pix;
  assign new_col[1] = mid_pix;
  assign new_col[2] = bot_pix;
  assign feed[2]    = new_col;
  assign feed[1]    = win_col[2];
  assign feed[0]    = win_col[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cell_ctl[i].adv = adv;
      cell_ctl[i].op  = WIN_HOLD;
    end
    if (fire) begin
      if (!b_phase) begin
        for (int i = 0; i < 3; i++) begin
          cell_ctl[i].op = b_col0 ? WIN_LOAD : WIN_SHIFT;
        end
      end else begin
        // second result of a row end: shift, rightmost column repeats
        cell_ctl[0].op = WIN_SHIFT;
        cell_ctl[1].op = WIN_SHIFT;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cell
    conv3_col_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl[i]),
      .new_col    (new_col),
      .from_right (feed[i]),
      .coefs      (coef[i*3 +: 3]),
      .col        (win_col[i]),
      .col_sum    (col_sums[i])
    );
  end

  always_comb begin
    emit_now.valid     = 1'b0;
    emit_now.row_end   = 1'b0;
    emit_now.frame_end = 1'b0;
    if (fire && b_rows) begin
      if (b_phase) begin
        emit_now.valid   = 1'b1;
        emit_now.row_end = 1'b1;
      end else if (!b_col0) begin
        emit_now.valid = 1'b1;
      end else if (b_last) begin
        emit_now.valid   = 1'b1;
        emit_now.row_end = 1'b1;
      end
      emit_now.frame_end = emit_now.row_end && b_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1 <= '0;
      e2 <= '0;
      e3 <= '0;
    end else if (adv) begin
      e1 <= emit_now;
      e2 <= e1;
      e3 <= e2;
    end
  end

  // ---------------------------------------------------------------- output
  conv3_reduce #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_reduce (
    .clk           (clk),
    .rst           (rst),
    .sums          (col_sums),
    .tag           (e3),
    .adv           (adv),
    .out_valid     (dst_valid),
    .out_stall     (dst_stall),
    .out_pix       (out_pix),
    .out_row_end   (row_end),
    .out_frame_end (frame_end)
  );

  assign red_out   = out_pix[0];
  assign green_out = out_pix[1];
  assign blue_out  = out_pix[2];
  assign alpha_out = out_pix[3];

`ifndef ASSERT_OFF
  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    b_phase |-> (b_valid && b_two))
    else $error("second row-end phase without a two-result pixel");

  a_skid_full: assert property (@(posedge clk) disable iff (rst)
    !adv |-> dst_valid)
    else $error("skid register full while output register empty");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && frame_end) |-> row_end)
    else $error("frame end beat without row end");

  a_hold_tags: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(e1) && $stable(e2) && $stable(e3)))
    else $error("result pipeline moved while stalled");
`endif

endmodule

// File: hdl/conv3_ram.sv
// ----------------------------------------------------------------------------
// conv3_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. Read data holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module conv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/conv3_col_cell.sv
// ----------------------------------------------------------------------------
// conv3_col_cell: one column of the 3x3 window
// Holds three pixels, passes them to the left neighbor on a shift, and
// forms the weighted column sum per channel over two register stages.
// ----------------------------------------------------------------------------
module conv3_col_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  conv3_pkg::win_ctl_t  ctl,
  input  conv3_pkg::column_t   new_col,
  input  conv3_pkg::column_t   from_right,
  input  conv3_pkg::coef_col_t coefs,
  output conv3_pkg::column_t   col,
  output conv3_pkg::col_sum_t  col_sum
);
  import conv3_pkg::*;

  logic [2:0][NUM_CH-1:0][PROD_W-1:0] prod;
  logic [2:0][NUM_CH-1:0][PROD_W-1:0] prod_next;
  col_sum_t                           col_sum_next;
  logic signed [COEF_W+CH_W:0]        full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else begin
      unique case (ctl.op)
        WIN_LOAD:  col <= new_col;
        WIN_SHIFT: col <= from_right;
        WIN_HOLD:  col <= col;
        default:   col <= col;
      endcase
    end
  end

  always_comb begin
    full = '0;
    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        full = $signed(coefs[r]) * $signed({1'b0, col[r][ch]});
        prod_next[r][ch] = full[PROD_W-1:0];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      col_sum_next[ch] = CSUM_W'($signed(prod[0][ch])) + CSUM_W'($signed(prod[1][ch]))
                       + CSUM_W'($signed(prod[2][ch]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod    <= prod_next;
      col_sum <= col_sum_next;
    end
  end

endmodule

// File: hdl/conv3_reduce.sv
// ----------------------------------------------------------------------------
// conv3_reduce: final sum, rounding, saturation and output buffering
// Adds the three column sums, rounds off the coefficient fraction, clamps
// to 0..255 and holds the result in an output register backed by a skid
// register.
// ----------------------------------------------------------------------------
module conv3_reduce #(
  parameter int COEF_FRAC_BITS = conv3_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  conv3_pkg::col_sum_t [2:0] sums,
  input  conv3_pkg::emit_tag_t      tag,
  output logic                      adv,
  output logic                      out_valid,
  input  logic                      out_stall,
  output conv3_pkg::pixel_t         out_pix,
  output logic                      out_row_end,
  output logic                      out_frame_end
);
  import conv3_pkg::*;

  localparam logic [TOT_W-1:0] ROUND = TOT_W'(1) << (COEF_FRAC_BITS - 1);

  logic [NUM_CH-1:0][TOT_W-1:0] total;
  logic [NUM_CH-1:0][TOT_W-1:0] shifted;
  pixel_t                       res;
  pixel_t                       skid_pix;
  logic                         skid_valid;
  logic                         skid_row_end;
  logic                         skid_frame_end;
  logic                         take;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total[ch] = TOT_W'($signed(sums[0][ch])) + TOT_W'($signed(sums[1][ch]))
                + TOT_W'($signed(sums[2][ch])) + ROUND;
      shifted[ch] = total[ch] >> COEF_FRAC_BITS;
      if (total[ch][TOT_W-1]) begin
        res[ch] = '0;
      end else if (|shifted[ch][TOT_W-1:CH_W]) begin
        res[ch] = '1;
      end else begin
        res[ch] = shifted[ch][CH_W-1:0];
      end
    end
  end

  assign adv  = !skid_valid;
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (tag.valid && adv) begin
      if (!out_valid || take) begin
        out_valid     <= 1'b1;
        out_pix       <= res;
        out_row_end   <= tag.row_end;
        out_frame_end <= tag.frame_end;
      end else begin
        skid_valid     <= 1'b1;
        skid_pix       <= res;
        skid_row_end   <= tag.row_end;
        skid_frame_end <= tag.frame_end;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid    <= 1'b0;
        out_pix       <= skid_pix;
        out_row_end   <= skid_row_end;
        out_frame_end <= skid_frame_end;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: tb/convolution_3x3_image_top_test.sv
// ----------------------------------------------------------------------------
// convolution_3x3_image_top_test: self-checking bench for the 3x3 RGBA filter
// Streams whole frames (pixel rows plus the flush row) under random source
// gaps and sink stalls. Each accepted pixel beat updates a local window and
// line-store model, which queues the expected filtered beats. Every result
// beat is checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module convolution_3x3_image_top_test;
  import conv3_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int FRAC          = DEF_COEF_FRAC_BITS;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 750;
  localparam int MAX_REPORTS   = 40;
  // index past the register map; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;

  typedef struct packed {
    pixel_t pix;
    logic   row_end;
    logic   frame_end;
  } filtered_t;

  typedef enum { FRAME_DIRECTED, FRAME_RANDOM } frame_kind_t;

  class rgba_conv_tracker;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [CFG_DATA_W-1:0] kern_low;
    logic [CFG_DATA_W-1:0] kern_mid;
    logic [COEF_W-1:0]     kern_top;
    pixel_t      upper_row [MAX_W];
    pixel_t      lower_row [MAX_W];
    pixel_t      win [9];
    int unsigned col;
    int unsigned row;
    filtered_t   due [$];
    int          errors;
    int          checked;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      kern_low   = KERNEL_LOW_RST;
      kern_mid   = KERNEL_MID_RST;
      kern_top   = KERNEL_TOP_RST;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col     = 0;
      row     = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:      width_reg = data[WIDTH_W-1:0];
        REG_HEIGHT:     height_reg = data[HEIGHT_W-1:0];
        REG_KERNEL_LOW: kern_low = data;
        REG_KERNEL_MID: kern_mid = data;
        REG_KERNEL_TOP: kern_top = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    function int coef(int k);
      logic [CFG_DATA_W-1:0]    word;
      logic signed [COEF_W-1:0] raw;
      word = (k < 4) ? kern_low : (k < 8) ? kern_mid : {48'd0, kern_top};
      raw  = word[16*(k%4) +: 16];
      return int'(raw);
    endfunction

    // window index is column * 3 + row, column 0 left, row 0 top
    function void load_column(int c, pixel_t top, pixel_t mid, pixel_t bot);
      win[c*3]     = top;
      win[c*3 + 1] = mid;
      win[c*3 + 2] = bot;
    endfunction

    function void shift_in(pixel_t top, pixel_t mid, pixel_t bot);
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      load_column(2, top, mid, bot);
    endfunction

    function void queue_filtered(bit rend, bit fend);
      filtered_t r;
      longint    sum;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum = 0;
        for (int i = 0; i < 9; i++) sum += longint'(coef(i)) * longint'(win[i][ch]);
        sum += longint'(1) << (FRAC - 1);
        if (sum < 0) begin
          sum = 0;
        end else begin
          sum = sum >>> FRAC;
          if (sum > 255) sum = 255;
        end
        r.pix[ch] = sum[CH_W-1:0];
      end
      r.row_end   = rend;
      r.frame_end = fend;
      due.push_back(r);
    endfunction

    function void take_pixel(logic pad, pixel_t in_pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      pixel_t      pix;
      pixel_t      top;
      pixel_t      mid;
      pixel_t      bot;
      bit          flush;
      bit          last;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      h = int'(height_reg);
      if (h < 1) h = 1;
      c = (col >= MAX_W) ? MAX_W - 1 : col;
      flush = row >= h;
      last  = c + 1 >= w;
      pix = pad ? '0 : in_pix;
      mid = lower_row[c];
      top = (row <= 1) ? mid : upper_row[c];
      bot = flush ? mid : pix;
      if (c == 0) begin
        load_column(0, top, mid, bot);
        load_column(1, top, mid, bot);
        load_column(2, top, mid, bot);
      end else begin
        shift_in(top, mid, bot);
      end
      upper_row[c] = mid;
      lower_row[c] = bot;
      if (row >= 1) begin
        if (c >= 1) queue_filtered(1'b0, 1'b0);
        // right edge repeats the last column
        if (last) begin
          if (c >= 1) shift_in(top, mid, bot);
          queue_filtered(1'b1, flush);
        end
      end
      if (last) begin
        col = 0;
        row = flush ? 0 : row + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void match_result(filtered_t got);
      filtered_t want;
      string     ch_name [NUM_CH] = '{"red", "green", "blue", "alpha"};
      if (due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat expected none got %h", $time, got);
        return;
      end
      want = due.pop_front();
      checked++;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (want.pix[ch] !== got.pix[ch]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: %s_out expected %0d got %0d", $time, ch_name[ch],
                     want.pix[ch], got.pix[ch]);
        end
      end
      if (want.row_end !== got.row_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: row_end expected %b got %b", $time, want.row_end, got.row_end);
      end
      if (want.frame_end !== got.frame_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end,
                   got.frame_end);
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  src_valid = 1'b0;
  logic                  src_stall;
  logic [CH_W-1:0]       red_in    = '0;
  logic [CH_W-1:0]       green_in  = '0;
  logic [CH_W-1:0]       blue_in   = '0;
  logic [CH_W-1:0]       alpha_in  = '0;
  logic                  pad_item  = 1'b0;
  logic                  dst_valid;
  logic                  dst_stall = 1'b0;
  logic [CH_W-1:0]       red_out;
  logic [CH_W-1:0]       green_out;
  logic [CH_W-1:0]       blue_out;
  logic [CH_W-1:0]       alpha_out;
  logic                  row_end;
  logic                  frame_end;

  rgba_conv_tracker tracker;
  int src_gap_pct   = 0;
  int sink_busy_pct = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int pixels_sent   = 0;
  int random_pixels = 0;
  int frames_run    = 0;
  bit paused_once   = 1'b0;

  convolution_3x3_image_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .pad_item  (pad_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("convolution_3x3_image_top_test: errors");
      $finish;
    end
  end

  // mostly short holds, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      dst_stall <= 1'b1;
    end else if ($urandom_range(99) < sink_busy_pct) begin
      hold_left = pick_gap() - 1;
      dst_stall <= 1'b1;
    end else begin
      dst_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (!rst && dst_valid && !dst_stall)
      tracker.match_result(filtered_t'({alpha_out, blue_out, green_out, red_out,
                                        row_end, frame_end}));

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait out every pending result, then let the pipe empty
  task automatic quiesce();
    src_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic pad, input pixel_t px);
    int gap;
    gap = ($urandom_range(99) < src_gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    red_in    <= px[0];
    green_in  <= px[1];
    blue_in   <= px[2];
    alpha_in  <= px[3];
    pad_item  <= pad;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    tracker.take_pixel(pad, px);
    pixels_sent++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_kernel();
    logic [CFG_DATA_W-1:0] word;
    case ($urandom_range(9))
      0: word = '0;
      1: word = '1;
      default: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(6))
            0:       word[16*i +: 16] = 16'($urandom);
            1:       word[16*i +: 16] = 16'($urandom_range(64));
            2:       word[16*i +: 16] = 16'($urandom_range(1023) - 512);
            3:       word[16*i +: 16] = 16'h7FFF;
            4:       word[16*i +: 16] = 16'h8000;
            5:       word[16*i +: 16] = 16'h0100;
            default: word[16*i +: 16] = 16'h0000;
          endcase
        end
      end
    endcase
    return word;
  endfunction

  // size value, sometimes with junk above the register width
  function automatic logic [CFG_DATA_W-1:0] size_word(int v, int bits);
    logic [CFG_DATA_W-1:0] word;
    word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
    word = (word & ~((64'd1 << bits) - 64'd1)) | CFG_DATA_W'(v);
    return word;
  endfunction

  task automatic set_size(input int w, input int h);
    set_reg(REG_WIDTH, size_word(w, WIDTH_W));
    set_reg(REG_HEIGHT, size_word(h, HEIGHT_W));
  endtask

  task automatic run_frame(input int w_cfg, input int h_cfg, input frame_kind_t kind);
    int     we;
    int     he;
    int     total;
    int     pause_at;
    int     n;
    logic   pad;
    pixel_t px;
    we = (w_cfg < 1) ? 1 : (w_cfg > MAX_W) ? MAX_W : w_cfg;
    he = (h_cfg < 1) ? 1 : h_cfg;
    total = we * (he + 1);
    pause_at = -1;
    if (kind == FRAME_RANDOM && (!paused_once || $urandom_range(3) == 0))
      pause_at = $urandom_range(total - 1);
    n = 0;
    for (int r = 0; r <= he; r++) begin
      for (int c = 0; c < we; c++) begin
        if (n == pause_at) begin
          quiesce();
          paused_once = 1'b1;
          if ($urandom_range(1) != 0) begin
            case ($urandom_range(2))
              0:       set_reg(REG_KERNEL_LOW, random_kernel());
              1:       set_reg(REG_KERNEL_MID, random_kernel());
              default: set_reg(REG_KERNEL_TOP, random_kernel());
            endcase
          end
        end
        px = $urandom;
        if (r == he) begin
          // flush row: channels should not matter either way
          pad = ($urandom_range(99) < 85);
        end else if (kind == FRAME_DIRECTED) begin
          pad = (r == 1 && c == 1);
          case ((r + c) % 3)
            0:       px = '0;
            1:       px = '1;
            default: ;
          endcase
        end else begin
          pad = ($urandom_range(99) < 5);
          case ($urandom_range(9))
            0:       px = '0;
            1:       px = '1;
            default: ;
          endcase
        end
        send_pixel(pad, px);
        n++;
      end
    end
    frames_run++;
    if (kind == FRAME_RANDOM) random_pixels += total;
  endtask

  initial begin
    int w;
    int h;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity kernel from reset, edge clamping, a pad in a pixel row
    set_size(3, 2);
    run_frame(3, 2, FRAME_DIRECTED);
    quiesce();
    set_reg(SPARE_REG_IDX, {$urandom, $urandom});
    // largest positive weights saturate high
    set_reg(REG_KERNEL_LOW, {4{16'h7FFF}});
    set_reg(REG_KERNEL_MID, {4{16'h7FFF}});
    set_reg(REG_KERNEL_TOP, 64'h7FFF);
    set_size(4, 1);
    run_frame(4, 1, FRAME_DIRECTED);
    quiesce();
    // most negative weights saturate low; single-column rows
    set_reg(REG_KERNEL_LOW, {4{16'h8000}});
    set_reg(REG_KERNEL_MID, {4{16'h8000}});
    set_reg(REG_KERNEL_TOP, 64'h8000);
    set_size(1, 3);
    run_frame(1, 3, FRAME_DIRECTED);
    quiesce();
    // zero sizes behave as one
    set_reg(REG_KERNEL_MID, 64'h0000_0000_0000_0100);
    set_size(0, 0);
    run_frame(0, 0, FRAME_DIRECTED);

    while (random_pixels < RANDOM_PIXELS) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      if ($urandom_range(19) == 0) w = 0;
      if ($urandom_range(19) == 0) h = 0;
      quiesce();
      src_gap_pct   = pick_pct();
      sink_busy_pct = pick_pct();
      set_size(w, h);
      if ($urandom_range(1) != 0) set_reg(REG_KERNEL_LOW, random_kernel());
      if ($urandom_range(1) != 0) set_reg(REG_KERNEL_MID, random_kernel());
      if ($urandom_range(1) != 0) set_reg(REG_KERNEL_TOP, random_kernel());
      run_frame(w, h, FRAME_RANDOM);
    end

    quiesce();
    $display("%0d frames, %0d pixel beats in, %0d result beats checked", frames_run,
             pixels_sent, tracker.checked);
    $display("frames up to 40 wide and 12 tall incl. zero sizes, saturating kernels,");
    $display("random source gaps and sink stalls, mid-frame pauses with kernel updates");
    if (tracker.errors == 0) begin
      $display("convolution_3x3_image_top_test: clean");
    end else begin
      $display("convolution_3x3_image_top_test: errors");
    end
    $finish;
  end
endmodule
